// ----- rtl/core/gmsp_pkg.sv -----
package gmsp_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 128;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);

  localparam int KIND_W   = 2;
  localparam int DIGIT_W  = 4;
  localparam int SCORE_W  = 12;
  localparam int COUNT_W  = 30;
  localparam int REG_W    = 8;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [COUNT_W-1:0] PRIME     = 30'd1000000007;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [REG_W-1:0] ROW_WIDTH_RST = 8'd128;
  localparam logic [REG_W-1:0] ROW_COUNT_RST = 8'd128;

  typedef enum logic [KIND_W-1:0] {
    KIND_DIGIT   = 2'd0,
    KIND_START   = 2'd1,
    KIND_END     = 2'd2,
    KIND_BLOCKED = 2'd3
  } kind_e;

  typedef enum logic {
    REG_ROW_WIDTH = 1'b0,
    REG_ROW_COUNT = 1'b1
  } reg_e;

  typedef struct packed {
    logic               reach;
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] count;
  } cell_val_t;

  typedef struct packed {
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic             restart;
  } grid_cfg_t;

  function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[COUNT_W-1:0];
  endfunction

  function automatic int unsigned last_index(input logic [REG_W-1:0] v,
                                             input int unsigned max_n);
    int unsigned n;
    n = int'(v);
    if (n == 0) begin
      return 0;
    end
    if (n > max_n) begin
      return max_n - 1;
    end
    return n - 1;
  endfunction

endpackage

// ----- rtl/core/gmsp_if.sv -----
interface gmsp_in_if;
  logic                         valid;
  logic                         ready;
  logic [gmsp_pkg::KIND_W-1:0]  cell_kind;
  logic [gmsp_pkg::DIGIT_W-1:0] digit;

  modport source (output valid, cell_kind, digit, input ready);
  modport sink   (input valid, cell_kind, digit, output ready);
endinterface

interface gmsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [gmsp_pkg::SCORE_W-1:0] best_score;
  logic [gmsp_pkg::COUNT_W-1:0] path_count;

  modport source (output valid, best_score, path_count, input ready);
  modport sink   (input valid, best_score, path_count, output ready);
endinterface

// ----- rtl/core/gmsp_cell.sv -----
module gmsp_cell (
  input  logic                  clk_i,
  input  logic                  shift_i,
  input  logic                  take_new_i,
  input  gmsp_pkg::cell_val_t   new_i,
  input  gmsp_pkg::cell_val_t   next_i,
  output gmsp_pkg::cell_val_t   val_o
);

  gmsp_pkg::cell_val_t val_d, val_q;

  always_comb begin
    val_d = val_q;
    if (shift_i) begin
      val_d = take_new_i ? new_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ----- rtl/core/gmsp_eval.sv -----
module gmsp_eval (
  input  gmsp_pkg::kind_e                kind_i,
  input  logic [gmsp_pkg::DIGIT_W-1:0]   digit_i,
  input  logic                           first_i,
  input  gmsp_pkg::cell_val_t            right_i,
  input  gmsp_pkg::cell_val_t            below_i,
  input  gmsp_pkg::cell_val_t            diag_i,
  output gmsp_pkg::cell_val_t            cur_o
);

  logic [gmsp_pkg::SCORE_W-1:0] rs, bs, ds, best;
  logic [gmsp_pkg::COUNT_W-1:0] rc, bc, dc;
  logic [gmsp_pkg::SCORE_W:0]   total;
  logic [gmsp_pkg::DIGIT_W-1:0] gain;
  logic                         any;

  always_comb begin
    rs   = right_i.reach ? right_i.score : '0;
    bs   = below_i.reach ? below_i.score : '0;
    ds   = diag_i.reach  ? diag_i.score  : '0;
    best = (rs > bs) ? rs : bs;
    best = (ds > best) ? ds : best;
    any  = right_i.reach | below_i.reach | diag_i.reach;

    rc = (right_i.reach && rs == best) ? right_i.count : '0;
    bc = (below_i.reach && bs == best) ? below_i.count : '0;
    dc = (diag_i.reach  && ds == best) ? diag_i.count  : '0;

    gain  = (kind_i == gmsp_pkg::KIND_DIGIT) ? digit_i : '0;
    total = {1'b0, best} + {{(gmsp_pkg::SCORE_W + 1 - gmsp_pkg::DIGIT_W){1'b0}}, gain};

    cur_o = '0;
    if (kind_i == gmsp_pkg::KIND_BLOCKED) begin
      cur_o = '0;
    end else if (first_i) begin
      cur_o.reach = 1'b1;
      cur_o.score = '0;
      cur_o.count = gmsp_pkg::COUNT_W'(1);
    end else if (any) begin
      cur_o.reach = 1'b1;
      cur_o.count = gmsp_pkg::add_mod(gmsp_pkg::add_mod(rc, bc), dc);
      cur_o.score = total[gmsp_pkg::SCORE_W] ? gmsp_pkg::SCORE_MAX
                                             : total[gmsp_pkg::SCORE_W-1:0];
    end
  end

endmodule

// ----- rtl/core/gmsp_regs.sv -----
module gmsp_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [gmsp_pkg::DATA_W-1:0]   pwdata,
  output logic [gmsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output gmsp_pkg::grid_cfg_t           cfg_o
);

  logic [gmsp_pkg::REG_W-1:0] row_width_d, row_width_q;
  logic [gmsp_pkg::REG_W-1:0] row_count_d, row_count_q;
  logic                       wr;
  gmsp_pkg::reg_e             sel;

  assign wr     = psel & penable & pwrite;
  assign sel    = gmsp_pkg::reg_e'(paddr[gmsp_pkg::ADDR_W-1]);
  assign pready = 1'b1;

  always_comb begin
    row_width_d = row_width_q;
    row_count_d = row_count_q;
    prdata      = '0;
    case (sel)
      gmsp_pkg::REG_ROW_WIDTH: begin
        prdata = {{(gmsp_pkg::DATA_W - gmsp_pkg::REG_W){1'b0}}, row_width_q};
        if (wr) row_width_d = pwdata[gmsp_pkg::REG_W-1:0];
      end
      gmsp_pkg::REG_ROW_COUNT: begin
        prdata = {{(gmsp_pkg::DATA_W - gmsp_pkg::REG_W){1'b0}}, row_count_q};
        if (wr) row_count_d = pwdata[gmsp_pkg::REG_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= gmsp_pkg::ROW_WIDTH_RST;
      row_count_q <= gmsp_pkg::ROW_COUNT_RST;
    end else begin
      row_width_q <= row_width_d;
      row_count_q <= row_count_d;
    end
  end

  assign cfg_o.last_col = gmsp_pkg::COL_W'(gmsp_pkg::last_index(row_width_q, gmsp_pkg::MAX_COLS));
  assign cfg_o.last_row = gmsp_pkg::ROW_W'(gmsp_pkg::last_index(row_count_q, gmsp_pkg::MAX_ROWS));
  assign cfg_o.restart  = wr;

endmodule

// ----- rtl/core/grid_max_score_path_counter.sv -----
// Channel  Dir  Word                      Handshake
// in_i     in   cell_kind, digit          valid/ready
// out_o    out  best_score, path_count    valid/ready
// apb      in   row_width, row_count      psel/penable, pready high
//
// One cell word per cycle unless stalled; result valid the cycle after last cell.
// The row buffer is a chain of MAX_COLS cells shifting one step per accepted word.
// Reset clears position and output valid; buffer contents stay undefined.
// A stalled result word holds in_i.ready low only while the next last cell waits.
module grid_max_score_path_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gmsp_in_if.sink                       in_i,
  gmsp_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gmsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [gmsp_pkg::DATA_W-1:0]   pwdata,
  output logic [gmsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  gmsp_pkg::grid_cfg_t cfg;
  gmsp_pkg::cell_val_t line_val [gmsp_pkg::MAX_COLS];
  gmsp_pkg::cell_val_t cur, below, right_m, diag_m;
  gmsp_pkg::cell_val_t right_d, right_q, diag_d, diag_q;

  logic [gmsp_pkg::COL_W-1:0]   col_d, col_q;
  logic [gmsp_pkg::ROW_W-1:0]   row_d, row_q;
  logic                         out_valid_d, out_valid_q;
  logic [gmsp_pkg::SCORE_W-1:0] best_d, best_q;
  logic [gmsp_pkg::COUNT_W-1:0] count_d, count_q;
  logic                         fire, first, last;

  gmsp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_i.ready = ~(last & out_valid_q & ~out_o.ready);
  assign fire       = in_i.valid & in_i.ready;
  assign first      = (col_q == '0) && (row_q == '0);
  assign last       = (col_q == cfg.last_col) && (row_q == cfg.last_row);

  assign below   = (row_q != '0) ? line_val[0] : '0;
  assign diag_m  = (row_q != '0 && col_q != '0) ? diag_q : '0;
  assign right_m = (col_q != '0) ? right_q : '0;

  gmsp_eval u_eval (
    .kind_i  (gmsp_pkg::kind_e'(in_i.cell_kind)),
    .digit_i (in_i.digit),
    .first_i (first),
    .right_i (right_m),
    .below_i (below),
    .diag_i  (diag_m),
    .cur_o   (cur)
  );

  for (genvar i = 0; i < gmsp_pkg::MAX_COLS; i++) begin : g_line
    if (i == gmsp_pkg::MAX_COLS - 1) begin : g_tail
      gmsp_cell u_cell (
        .clk_i      (clk_i),
        .shift_i    (fire),
        .take_new_i (1'b1),
        .new_i      (cur),
        .next_i     (cur),
        .val_o      (line_val[i])
      );
    end else begin : g_body
      gmsp_cell u_cell (
        .clk_i      (clk_i),
        .shift_i    (fire),
        .take_new_i (cfg.last_col == gmsp_pkg::COL_W'(i)),
        .new_i      (cur),
        .next_i     (line_val[i+1]),
        .val_o      (line_val[i])
      );
    end
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    right_d     = right_q;
    diag_d      = diag_q;
    out_valid_d = out_valid_q;
    best_d      = best_q;
    count_d     = count_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (cfg.restart) begin
      col_d   = '0;
      row_d   = '0;
      right_d = '0;
      diag_d  = '0;
    end else if (fire) begin
      right_d = cur;
      diag_d  = below;
      if (last) begin
        col_d       = '0;
        row_d       = '0;
        right_d     = '0;
        diag_d      = '0;
        out_valid_d = 1'b1;
        best_d      = cur.reach ? cur.score : '0;
        count_d     = cur.reach ? cur.count : '0;
      end else if (col_q == cfg.last_col) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      right_q     <= '0;
      diag_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      right_q     <= right_d;
      diag_q      <= diag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    count_q <= count_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.best_score = best_q;
  assign out_o.path_count = count_q;

endmodule

// ----- rtl/core/gmsp_checker.sv -----
module gmsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [gmsp_pkg::SCORE_W-1:0]  best_score_i,
  input logic [gmsp_pkg::COUNT_W-1:0]  path_count_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(best_score_i) && $stable(path_count_i))
    else $error("result word changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> path_count_i < gmsp_pkg::PRIME)
    else $error("path count not reduced");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without pending result");

endmodule

bind grid_max_score_path_counter gmsp_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .best_score_i (out_o.best_score),
  .path_count_i (out_o.path_count)
);
